// File: sv/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Types and constants shared by the pixel stretch top level and its lane.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pls_pkg;

  localparam int unsigned NumStages = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;
  localparam logic [7:0]  LevelMax  = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFirstIn   = 3'd0,
    CfgFirstOut  = 3'd1,
    CfgSecondIn  = 3'd2,
    CfgSecondOut = 3'd3,
    CfgColorMode = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] first_in;
    logic [7:0] first_out;
    logic [7:0] second_in;
    logic [7:0] second_out;
    logic       color_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] pixel_c0;
    logic [7:0] pixel_c1;
    logic [7:0] pixel_c2;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] mapped_c0;
    logic [7:0] mapped_c1;
    logic [7:0] mapped_c2;
  } pix_out_t;

endpackage

// File: sv/pls_lane.sv
// ----------------------------------------------------------------------------
// pls_lane
// One channel of the stretch: segment select, two products, rounded
// dividend, then a restoring divide at two quotient bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pls_lane
  import pls_pkg::*;
(
  input  logic                 clk_i,
  input  logic [NumStages-1:0] en_i,
  input  logic [7:0]           x_i,
  input  cfg_t                 cfg_i,
  output logic [7:0]           y_o
);

  localparam int unsigned DivSteps = 4;

  // stage 0: input
  logic [7:0] x0_q;

  // stage 1: operands of n = p*u + q*v, denominator d
  logic [7:0] p_d, u_d, q_d, v_d, den_d;
  logic [7:0] p_q, u_q, q_q, v_q, den1_q;

  // stage 2: products
  logic [15:0] pa_q, pb_q;
  logic [7:0]  den2_q;

  // stages 3..7: remainder, divisor and quotient
  logic [16:0] num_d;
  logic [16:0] rem_q [0:DivSteps];
  logic [8:0]  dvs_q [0:DivSteps];
  logic [7:0]  quo_q [0:DivSteps];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x0_q <= x_i;
    end
  end

  always_comb begin
    priority if (x0_q < cfg_i.first_in) begin
      p_d   = cfg_i.first_out;
      u_d   = x0_q;
      q_d   = '0;
      v_d   = '0;
      den_d = cfg_i.first_in;
    end else if (x0_q < cfg_i.second_in) begin
      p_d   = cfg_i.first_out;
      u_d   = cfg_i.second_in - x0_q;
      q_d   = cfg_i.second_out;
      v_d   = x0_q - cfg_i.first_in;
      den_d = cfg_i.second_in - cfg_i.first_in;
    end else if (cfg_i.second_in == LevelMax) begin
      // flat top: result is second_out itself
      p_d   = cfg_i.second_out;
      u_d   = 8'd1;
      q_d   = '0;
      v_d   = '0;
      den_d = 8'd1;
    end else begin
      p_d   = cfg_i.second_out;
      u_d   = LevelMax - x0_q;
      q_d   = LevelMax;
      v_d   = x0_q - cfg_i.second_in;
      den_d = LevelMax - cfg_i.second_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q    <= p_d;
      u_q    <= u_d;
      q_q    <= q_d;
      v_q    <= v_d;
      den1_q <= den_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      pa_q   <= p_q * u_q;
      pb_q   <= q_q * v_q;
      den2_q <= den1_q;
    end
  end

  // 2n + d never exceeds 511 * 255
  always_comb begin
    num_d = {(pa_q + pb_q), 1'b0} + 17'(den2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      rem_q[0] <= num_d;
      dvs_q[0] <= {den2_q, 1'b0};
      quo_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    localparam int unsigned ShHi = 7 - 2 * j;
    localparam int unsigned ShLo = 6 - 2 * j;

    logic [16:0] dhi, dlo, rem_mid, rem_nxt;
    logic        bit_hi, bit_lo;

    always_comb begin
      dhi     = 17'(dvs_q[j]) << ShHi;
      dlo     = 17'(dvs_q[j]) << ShLo;
      bit_hi  = rem_q[j] >= dhi;
      rem_mid = bit_hi ? rem_q[j] - dhi : rem_q[j];
      bit_lo  = rem_mid >= dlo;
      rem_nxt = bit_lo ? rem_mid - dlo : rem_mid;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[4+j]) begin
        rem_q[j+1] <= rem_nxt;
        dvs_q[j+1] <= dvs_q[j];
        quo_q[j+1] <= {quo_q[j][5:0], bit_hi, bit_lo};
      end
    end
  end

  assign y_o = quo_q[DivSteps];

endmodule

// File: sv/piecewise_linear_pixel_stretch.sv
// ----------------------------------------------------------------------------
// piecewise_linear_pixel_stretch
// Three-segment linear stretch of each pixel channel, rounded half up; in gray
// mode channels 1 and 2 are output as zero. Each accepted item passes through
// 8 register stages, depth set by the divide at two quotient bits per stage.
// Throughput: 1/cycle unless stalled. An output stall holds only full stages;
// input stalls once all 8 are full. Reset clears the stage valid bits and
// loads 64/32, 192/224 and gray mode.
`timescale 1ns / 1ps

module piecewise_linear_pixel_stretch
  import pls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pix_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pix_out_t            out_data_o
);

  localparam int unsigned Last = NumStages - 1;

  cfg_t                 cfg_q;
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;
  logic [Last:1]        mode_q;
  logic [7:0]           y0, y1, y2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_in   <= 8'd64;
      cfg_q.first_out  <= 8'd32;
      cfg_q.second_in  <= 8'd192;
      cfg_q.second_out <= 8'd224;
      cfg_q.color_mode <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFirstIn:   cfg_q.first_in   <= cfg_wdata_i;
        CfgFirstOut:  cfg_q.first_out  <= cfg_wdata_i;
        CfgSecondIn:  cfg_q.second_in  <= cfg_wdata_i;
        CfgSecondOut: cfg_q.second_out <= cfg_wdata_i;
        CfgColorMode: cfg_q.color_mode <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // a stage moves when it is empty or the next one moves
  assign en[Last] = !valid_q[Last] || !out_stall_i;
  for (genvar k = 0; k < Last; k++) begin : g_en
    assign en[k] = !valid_q[k] || en[k+1];
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      mode_q[1] <= cfg_q.color_mode;
    end
    for (int k = 2; k < NumStages; k++) begin
      if (en[k]) begin
        mode_q[k] <= mode_q[k-1];
      end
    end
  end

  pls_lane u_lane0 (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (in_data_i.pixel_c0),
    .cfg_i (cfg_q),
    .y_o   (y0)
  );

  pls_lane u_lane1 (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (in_data_i.pixel_c1),
    .cfg_i (cfg_q),
    .y_o   (y1)
  );

  pls_lane u_lane2 (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (in_data_i.pixel_c2),
    .cfg_i (cfg_q),
    .y_o   (y2)
  );

  assign out_valid_o          = valid_q[Last];
  assign out_data_o.mapped_c0 = y0;
  assign out_data_o.mapped_c1 = mode_q[Last] ? y1 : 8'd0;
  assign out_data_o.mapped_c2 = mode_q[Last] ? y2 : 8'd0;

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while pipeline has a free stage");

  a_gray_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !mode_q[Last]) |->
      (out_data_o.mapped_c1 == 8'd0 && out_data_o.mapped_c2 == 8'd0))
    else $error("gray item carries nonzero color channels");

  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(valid_q[Last-1]))
    else $error("result appeared without an item in the stage before");
`endif

endmodule

// File: dv/tb_piecewise_linear_pixel_stretch.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_pixel_stretch
// Self-checking bench for the three-segment pixel stretch. A scoreboard
// predicts every mapped pixel from its own copy of the breakpoints and checks
// results in order. Directed corner pixels come first, then random phases with
// fresh breakpoints, random idling on both sides and long output holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_piecewise_linear_pixel_stretch;
  import pls_pkg::*;

  localparam int unsigned LatencyCycles = 8;
  localparam int unsigned DrainCycles   = LatencyCycles + 8;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned RandPhases    = 12;
  localparam int unsigned PhaseItems    = 128;

  class stretch_scoreboard;
    cfg_t        cfg;
    pix_out_t    expected_pixels[$];
    int unsigned mismatches;

    function new();
      cfg.first_in   = 8'd64;
      cfg.first_out  = 8'd32;
      cfg.second_in  = 8'd192;
      cfg.second_out = 8'd224;
      cfg.color_mode = 1'b0;
      mismatches     = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [7:0] value);
      case (idx)
        CfgFirstIn:   cfg.first_in   = value;
        CfgFirstOut:  cfg.first_out  = value;
        CfgSecondIn:  cfg.second_in  = value;
        CfgSecondOut: cfg.second_out = value;
        CfgColorMode: cfg.color_mode = value[0];
        default: ;
      endcase
    endfunction

    // exact point on the curve, rounded half up: floor((2n + d) / 2d)
    function logic [7:0] stretch_level(logic [7:0] x);
      int unsigned xi, x1, y1, x2, y2, top, num, den;
      xi  = x;
      x1  = cfg.first_in;
      y1  = cfg.first_out;
      x2  = cfg.second_in;
      y2  = cfg.second_out;
      top = LevelMax;
      if (xi < x1) begin
        num = y1 * xi;
        den = x1;
      end else if (xi < x2) begin
        num = y1 * (x2 - xi) + y2 * (xi - x1);
        den = x2 - x1;
      end else if (x2 >= top) begin
        return cfg.second_out;
      end else begin
        num = y2 * (top - xi) + top * (xi - x2);
        den = top - x2;
      end
      return 8'((2 * num + den) / (2 * den));
    endfunction

    function void note_pixel(pix_in_t px);
      pix_out_t exp_px;
      exp_px.mapped_c0 = stretch_level(px.pixel_c0);
      exp_px.mapped_c1 = cfg.color_mode ? stretch_level(px.pixel_c1) : 8'd0;
      exp_px.mapped_c2 = cfg.color_mode ? stretch_level(px.pixel_c2) : 8'd0;
      expected_pixels.push_back(exp_px);
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t exp_px;
      if (expected_pixels.size() == 0) begin
        $error("result with no pending item: %h", got);
        mismatches++;
        return;
      end
      exp_px = expected_pixels.pop_front();
      compare_field("mapped_c0", exp_px.mapped_c0, got.mapped_c0);
      compare_field("mapped_c1", exp_px.mapped_c1, got.mapped_c1);
      compare_field("mapped_c2", exp_px.mapped_c2, got.mapped_c2);
    endfunction
  endclass

  logic           clk_i      = 1'b0;
  logic           rst_ni     = 1'b0;
  logic           cfg_we     = 1'b0;
  cfg_idx_e       cfg_idx    = CfgFirstIn;
  logic [7:0]     cfg_wdata  = 8'd0;
  logic           in_valid   = 1'b0;
  logic           in_stall;
  pix_in_t        in_data    = '0;
  logic           out_valid;
  logic           out_stall  = 1'b0;
  pix_out_t       out_data;

  bit             tx_idle    = 1'b1;
  bit             rx_idle    = 1'b1;
  bit             hold_req   = 1'b0;

  stretch_scoreboard pixel_sb = new();

  piecewise_linear_pixel_stretch DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // output side: random stall per item, plus long holds on request
  initial begin : result_sink
    int unsigned wait_left;
    int unsigned hold_left;
    wait_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) begin
        pixel_sb.check_pixel(out_data);
        wait_left = rx_idle ? $urandom_range(0, 19) : 0;
      end else if (wait_left > 0) begin
        wait_left--;
      end
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (wait_left > 0) || (hold_left > 0);
    end
  end

  task automatic send_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    pix_in_t     px;
    int unsigned gap;
    px.pixel_c0 = c0;
    px.pixel_c1 = c1;
    px.pixel_c2 = c2;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk_i); while (in_stall);
    pixel_sb.note_pixel(px);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pixel_sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    pixel_sb.write_reg(idx, value);
  endtask

  task automatic apply_cfg(logic [7:0] fi, logic [7:0] fo, logic [7:0] si,
                           logic [7:0] so, logic cm);
    wait_idle();
    write_reg(CfgFirstIn, fi);
    write_reg(CfgFirstOut, fo);
    write_reg(CfgSecondIn, si);
    write_reg(CfgSecondOut, so);
    write_reg(CfgColorMode, {7'd0, cm});
  endtask

  function automatic logic [7:0] rand_breakpoint();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      3:       return 8'd254;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // biased toward the segment boundaries
  function automatic logic [7:0] rand_level();
    logic [7:0] lvl;
    case ($urandom_range(0, 7))
      0:       lvl = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      1:       lvl = pixel_sb.cfg.first_in + 8'($urandom_range(0, 2)) - 8'd1;
      2:       lvl = pixel_sb.cfg.second_in + 8'($urandom_range(0, 2)) - 8'd1;
      default: lvl = 8'($urandom_range(0, 255));
    endcase
    return lvl;
  endfunction

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset breakpoints, gray: upper channels must be ignored
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd63, 8'd170, 8'd85);
    send_pixel(8'd64, 8'd1, 8'd254);
    send_pixel(8'd191, 8'd128, 8'd127);
    send_pixel(8'd192, 8'd255, 8'd0);
    send_pixel(8'd128, 8'd170, 8'd85);

    // first breakpoint at zero, second at full scale
    apply_cfg(8'd0, 8'd0, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd128, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd1);
    send_pixel(8'd127, 8'd0, 8'd255);

    // crossed breakpoints
    apply_cfg(8'd200, 8'd10, 8'd50, 8'd250, 1'b1);
    send_pixel(8'd199, 8'd200, 8'd49);
    send_pixel(8'd50, 8'd255, 8'd0);

    // both breakpoints at full scale, inverted end
    apply_cfg(8'd255, 8'd255, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd1, 8'd128, 8'd253);

    // steep narrow segments
    apply_cfg(8'd1, 8'd255, 8'd2, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd1, 8'd2);
    send_pixel(8'd255, 8'd3, 8'd128);

    for (int unsigned k = 0; k < RandPhases; k++) begin
      apply_cfg(rand_breakpoint(), rand_breakpoint(), rand_breakpoint(),
                rand_breakpoint(), (k % 3) != 0);
      tx_idle = (k % 3) != 0;
      rx_idle = (k % 4) != 1;
      if (k == 2 || k == 7) begin
        tx_idle  = 1'b0;
        hold_req = 1'b1;
      end
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        send_pixel(rand_level(), rand_level(), rand_level());
      end
    end

    wait_idle();
    if (pixel_sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
